// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the surface extraction RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising edge outside reset.
`define VSE_ASSERT(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define VSE_ASSERT_NEXT(name, clk, rst, cause, effect, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ----- rtl/vse_pkg.sv -----
// Shared constants and types for the 3D voxel surface extraction block.
// No dependencies.
package vse_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_DEPTH  = 4096;

   localparam int WIDTH_REG_W  = 7;
   localparam int HEIGHT_REG_W = 7;
   localparam int DEPTH_REG_W  = 13;

   localparam int WIDTH_RESET  = 64;
   localparam int HEIGHT_RESET = 64;
   localparam int DEPTH_RESET  = 64;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int PLANE_W = $clog2(MAX_DEPTH);

   localparam int MAX_PLANE   = MAX_WIDTH * MAX_HEIGHT;
   localparam int PROD_W      = WIDTH_REG_W + HEIGHT_REG_W;
   localparam int PLANE_LEN_W = $clog2(MAX_PLANE + 1);
   localparam int SPAN_B_W    = PLANE_LEN_W + 1;
   localparam int LAG_W       = $clog2(MAX_PLANE + MAX_WIDTH + 2);
   localparam int ROW_SPAN_W  = WIDTH_REG_W + 1;

   localparam int PTR_A_W  = $clog2(MAX_PLANE);
   localparam int PTR_B_W  = $clog2(2 * MAX_PLANE);
   localparam int PTR_R1_W = $clog2(MAX_WIDTH);
   localparam int PTR_R2_W = $clog2(2 * MAX_WIDTH);

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_DEPTH  = 2'd2
   } vse_reg_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic border;
   } vse_ctrl_type;

   // [row delay][plane delay] occupancy taps of one stream position
   typedef logic [2:0][2:0] vse_slice_type;

endpackage

// ----- rtl/voxel_surface_extract_3d_top.sv -----
// Voxel surface extraction top level. Accepts one request per cycle unless
// result back-pressure stalls it. Results pass the plane RAM, row RAM, window
// and result registers. The result for a voxel is caused by the request
// W*H+W+1 positions later. Synchronous active-high reset sets the size
// registers to 64 and clears all counters; buffer RAMs are not cleared.
module voxel_surface_extract_3d_top import vse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic                  req_occupied,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_surface,
   output logic                  rsp_last
);

   logic                   push_valid;
   logic                   push_ready;
   logic                   push_occ;
   vse_ctrl_type           push_ctrl;
   logic                   restart;
   logic [PLANE_LEN_W-1:0] plane_len;
   logic [WIDTH_REG_W-1:0] row_len;
   logic                   s1_valid;
   logic                   s1_ready;
   logic [2:0]             s1_taps;
   vse_ctrl_type           s1_ctrl;
   logic                   s2_valid;
   logic                   s2_ready;
   vse_slice_type          s2_slice;
   vse_ctrl_type           s2_ctrl;

   assign pready = 1'b1;

   vse_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .req_valid    (req_valid),
      .req_mode     (req_mode),
      .req_occupied (req_occupied),
      .req_ready    (req_ready),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_occ     (push_occ),
      .push_ctrl    (push_ctrl),
      .restart      (restart),
      .plane_len    (plane_len),
      .row_len      (row_len)
   );

   vse_plane_buf u_plane_buf (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .plane_len  (plane_len),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_occ   (push_occ),
      .push_ctrl  (push_ctrl),
      .s1_valid   (s1_valid),
      .s1_ready   (s1_ready),
      .s1_taps    (s1_taps),
      .s1_ctrl    (s1_ctrl)
   );

   vse_row_buf u_row_buf (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .row_len  (row_len),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_taps  (s1_taps),
      .s1_ctrl  (s1_ctrl),
      .s2_valid (s2_valid),
      .s2_ready (s2_ready),
      .s2_slice (s2_slice),
      .s2_ctrl  (s2_ctrl)
   );

   vse_window u_window (
      .clock       (clock),
      .reset       (reset),
      .s2_valid    (s2_valid),
      .s2_ready    (s2_ready),
      .s2_slice    (s2_slice),
      .s2_ctrl     (s2_ctrl),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_surface (rsp_surface),
      .rsp_last    (rsp_last)
   );

endmodule

// ----- rtl/vse_ram.sv -----
// Generic single-port RAM with registered read of the old contents.
// No dependencies.
module vse_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= mem_ff[addr];
         mem_ff[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/vse_ctrl.sv -----
// Register file, volume geometry and stream counters of the surface extractor.
// Depends on vse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vse_ctrl import vse_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  logic                   req_occupied,
   output logic                   req_ready,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic                   push_occ,
   output vse_ctrl_type           push_ctrl,
   output logic                   restart,
   output logic [PLANE_LEN_W-1:0] plane_len,
   output logic [WIDTH_REG_W-1:0] row_len
);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [DEPTH_REG_W-1:0]  depth_ff, depth_in;

   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [ROW_W-1:0]   in_row_ff, in_row_in;
   logic [PLANE_W-1:0] in_plane_ff, in_plane_in;
   logic               in_done_ff, in_done_in;
   logic [LAG_W-1:0]   warm_ff, warm_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [PLANE_W-1:0] out_plane_ff, out_plane_in;

   logic [WIDTH_REG_W-1:0]  w_eff;
   logic [HEIGHT_REG_W-1:0] h_eff;
   logic [DEPTH_REG_W-1:0]  d_eff;
   logic [PROD_W-1:0]       plane_prod;
   logic [LAG_W-1:0]        lag;
   logic [COL_W-1:0]        w_last;
   logic [ROW_W-1:0]        h_last;
   logic [PLANE_W-1:0]      d_last;
   vse_reg_type             reg_sel;
   logic                    csr_write;
   logic                    ignored;
   logic                    fire;
   logic                    emit;
   logic                    at_last;
   logic                    at_in_end;
   logic                    border;
   logic                    clear_vol;

   // Out-of-range sizes act as the nearest legal size.
   always_comb begin
      if (width_ff == '0) w_eff = WIDTH_REG_W'(1);
      else if (width_ff > WIDTH_REG_W'(MAX_WIDTH)) w_eff = WIDTH_REG_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = HEIGHT_REG_W'(1);
      else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
      else h_eff = height_ff;
      if (depth_ff == '0) d_eff = DEPTH_REG_W'(1);
      else if (depth_ff > DEPTH_REG_W'(MAX_DEPTH)) d_eff = DEPTH_REG_W'(MAX_DEPTH);
      else d_eff = depth_ff;
   end

   assign plane_prod = PROD_W'(w_eff) * PROD_W'(h_eff);
   assign plane_len  = PLANE_LEN_W'(plane_prod);
   assign row_len    = w_eff;
   assign lag        = LAG_W'(plane_len) + LAG_W'(w_eff) + LAG_W'(1);
   assign w_last     = COL_W'(w_eff - WIDTH_REG_W'(1));
   assign h_last     = ROW_W'(h_eff - HEIGHT_REG_W'(1));
   assign d_last     = PLANE_W'(d_eff - DEPTH_REG_W'(1));

   assign csr_write = psel & penable & pwrite;
   assign reg_sel   = vse_reg_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      restart   = 1'b0;
      if (csr_write) begin
         case (reg_sel)
            REG_WIDTH: begin
               width_in = pwdata[WIDTH_REG_W-1:0];
               restart  = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = pwdata[HEIGHT_REG_W-1:0];
               restart   = 1'b1;
            end
            REG_DEPTH: begin
               depth_in = pwdata[DEPTH_REG_W-1:0];
               restart  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_DEPTH:  prdata = CSR_DATA_W'(depth_ff);
         default:    prdata = '0;
      endcase
   end

   // A drain request before the volume is complete is taken and dropped.
   assign ignored    = req_mode & ~in_done_ff;
   assign push_valid = req_valid & ~ignored;
   assign req_ready  = push_ready;
   assign fire       = push_valid & push_ready;
   assign push_occ   = req_occupied & ~req_mode & ~in_done_ff;

   assign emit      = (warm_ff == lag);
   assign at_in_end = (in_col_ff == w_last) && (in_row_ff == h_last) && (in_plane_ff == d_last);
   assign at_last   = (out_col_ff == w_last) && (out_row_ff == h_last) &&
                      (out_plane_ff == d_last);
   assign border    = (out_col_ff == '0) || (out_col_ff == w_last) ||
                      (out_row_ff == '0) || (out_row_ff == h_last) ||
                      (out_plane_ff == '0) || (out_plane_ff == d_last);

   always_comb begin
      push_ctrl.emit   = emit;
      push_ctrl.last   = emit & at_last;
      push_ctrl.border = border;
   end

   assign clear_vol = restart | (fire & emit & at_last);

   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_plane_in  = in_plane_ff;
      in_done_in   = in_done_ff;
      warm_in      = warm_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_plane_in = out_plane_ff;
      if (fire) begin
         if (!in_done_ff) begin
            if (at_in_end) begin
               in_col_in   = '0;
               in_row_in   = '0;
               in_plane_in = '0;
               in_done_in  = 1'b1;
            end else if (in_col_ff == w_last) begin
               in_col_in = '0;
               if (in_row_ff == h_last) begin
                  in_row_in   = '0;
                  in_plane_in = in_plane_ff + PLANE_W'(1);
               end else begin
                  in_row_in = in_row_ff + ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (!emit) begin
            warm_in = warm_ff + LAG_W'(1);
         end else if (out_col_ff == w_last) begin
            out_col_in = '0;
            if (out_row_ff == h_last) begin
               out_row_in   = '0;
               out_plane_in = out_plane_ff + PLANE_W'(1);
            end else begin
               out_row_in = out_row_ff + ROW_W'(1);
            end
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
      // Last result or register write: start a new volume.
      if (clear_vol) begin
         in_col_in    = '0;
         in_row_in    = '0;
         in_plane_in  = '0;
         in_done_in   = 1'b0;
         warm_in      = '0;
         out_col_in   = '0;
         out_row_in   = '0;
         out_plane_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_REG_W'(WIDTH_RESET);
         height_ff    <= HEIGHT_REG_W'(HEIGHT_RESET);
         depth_ff     <= DEPTH_REG_W'(DEPTH_RESET);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_plane_ff  <= '0;
         in_done_ff   <= 1'b0;
         warm_ff      <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_plane_ff <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         depth_ff     <= depth_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_plane_ff  <= in_plane_in;
         in_done_ff   <= in_done_in;
         warm_ff      <= warm_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_plane_ff <= out_plane_in;
      end
   end

   `VSE_ASSERT(a_warm_bounded, clock, reset, warm_ff <= lag, "warm-up count passed the lag")
   `VSE_ASSERT_NEXT(a_last_restarts, clock, reset, fire && emit && at_last, (warm_ff == '0) && !in_done_ff && (out_plane_ff == '0), "volume did not restart after its last result")

endmodule

// ----- rtl/vse_plane_buf.sv -----
// Plane delay stage: delays the occupancy stream by one and two planes.
// Depends on vse_pkg, vse_ram and assert_macros.svh.
`include "assert_macros.svh"

module vse_plane_buf import vse_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic [PLANE_LEN_W-1:0] plane_len,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  logic                   push_occ,
   input  vse_ctrl_type           push_ctrl,
   output logic                   s1_valid,
   input  logic                   s1_ready,
   output logic [2:0]             s1_taps,
   output vse_ctrl_type           s1_ctrl
);

   logic [PTR_A_W-1:0] ptr_a_ff, ptr_a_in;
   logic [PTR_B_W-1:0] ptr_b_ff, ptr_b_in;
   logic               valid_ff, valid_in;
   logic               occ_ff, occ_in;
   vse_ctrl_type       ctrl_ff, ctrl_in;

   logic                   load;
   logic [PLANE_LEN_W-1:0] span_a_last;
   logic [SPAN_B_W-1:0]    span_b_last;
   logic                   occ_a;
   logic                   occ_b;

   assign push_ready  = ~valid_ff | s1_ready;
   assign load        = push_valid & push_ready;
   assign span_a_last = plane_len - PLANE_LEN_W'(1);
   assign span_b_last = {plane_len, 1'b0} - SPAN_B_W'(1);

   // Wrap each pointer at its delay length so a read returns the value
   // written that many requests earlier.
   always_comb begin
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      if (restart) begin
         ptr_a_in = '0;
         ptr_b_in = '0;
      end else if (load) begin
         ptr_a_in = (PLANE_LEN_W'(ptr_a_ff) == span_a_last) ? '0 : ptr_a_ff + PTR_A_W'(1);
         ptr_b_in = (SPAN_B_W'(ptr_b_ff) == span_b_last) ? '0 : ptr_b_ff + PTR_B_W'(1);
      end
   end

   assign valid_in = load | (valid_ff & ~s1_ready);
   assign occ_in   = load ? push_occ : occ_ff;
   assign ctrl_in  = load ? push_ctrl : ctrl_ff;

   vse_ram #(.DEPTH(MAX_PLANE), .WIDTH(1)) u_ram_a (
      .clock (clock),
      .en    (load),
      .addr  (ptr_a_ff),
      .wdata (push_occ),
      .rdata (occ_a)
   );

   vse_ram #(.DEPTH(2 * MAX_PLANE), .WIDTH(1)) u_ram_b (
      .clock (clock),
      .en    (load),
      .addr  (ptr_b_ff),
      .wdata (push_occ),
      .rdata (occ_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_a_ff <= '0;
         ptr_b_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         ptr_a_ff <= ptr_a_in;
         ptr_b_ff <= ptr_b_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      occ_ff  <= occ_in;
      ctrl_ff <= ctrl_in;
   end

   assign s1_valid = valid_ff;
   assign s1_taps  = {occ_b, occ_a, occ_ff};
   assign s1_ctrl  = ctrl_ff;

   `VSE_ASSERT(a_plane_ptr_in_span, clock, reset, (PLANE_LEN_W'(ptr_a_ff) < plane_len) && (SPAN_B_W'(ptr_b_ff) <= span_b_last), "plane buffer pointer outside its delay span")

endmodule

// ----- rtl/vse_row_buf.sv -----
// Row delay stage: delays the three plane-aligned streams by one and two rows.
// Depends on vse_pkg, vse_ram and assert_macros.svh.
`include "assert_macros.svh"

module vse_row_buf import vse_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic [WIDTH_REG_W-1:0] row_len,
   input  logic                   s1_valid,
   output logic                   s1_ready,
   input  logic [2:0]             s1_taps,
   input  vse_ctrl_type           s1_ctrl,
   output logic                   s2_valid,
   input  logic                   s2_ready,
   output vse_slice_type          s2_slice,
   output vse_ctrl_type           s2_ctrl
);

   logic [PTR_R1_W-1:0] ptr_r1_ff, ptr_r1_in;
   logic [PTR_R2_W-1:0] ptr_r2_ff, ptr_r2_in;
   logic                valid_ff, valid_in;
   logic [2:0]          taps_ff, taps_in;
   vse_ctrl_type        ctrl_ff, ctrl_in;

   logic                   load;
   logic [WIDTH_REG_W-1:0] span_r1_last;
   logic [ROW_SPAN_W-1:0]  span_r2_last;
   logic [2:0]             row_1;
   logic [2:0]             row_2;

   assign s1_ready     = ~valid_ff | s2_ready;
   assign load         = s1_valid & s1_ready;
   assign span_r1_last = row_len - WIDTH_REG_W'(1);
   assign span_r2_last = {row_len, 1'b0} - ROW_SPAN_W'(1);

   always_comb begin
      ptr_r1_in = ptr_r1_ff;
      ptr_r2_in = ptr_r2_ff;
      if (restart) begin
         ptr_r1_in = '0;
         ptr_r2_in = '0;
      end else if (load) begin
         ptr_r1_in = (WIDTH_REG_W'(ptr_r1_ff) == span_r1_last) ? '0 :
                     ptr_r1_ff + PTR_R1_W'(1);
         ptr_r2_in = (ROW_SPAN_W'(ptr_r2_ff) == span_r2_last) ? '0 :
                     ptr_r2_ff + PTR_R2_W'(1);
      end
   end

   assign valid_in = load | (valid_ff & ~s2_ready);
   assign taps_in  = load ? s1_taps : taps_ff;
   assign ctrl_in  = load ? s1_ctrl : ctrl_ff;

   vse_ram #(.DEPTH(MAX_WIDTH), .WIDTH(3)) u_ram_r1 (
      .clock (clock),
      .en    (load),
      .addr  (ptr_r1_ff),
      .wdata (s1_taps),
      .rdata (row_1)
   );

   vse_ram #(.DEPTH(2 * MAX_WIDTH), .WIDTH(3)) u_ram_r2 (
      .clock (clock),
      .en    (load),
      .addr  (ptr_r2_ff),
      .wdata (s1_taps),
      .rdata (row_2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_r1_ff <= '0;
         ptr_r2_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         ptr_r1_ff <= ptr_r1_in;
         ptr_r2_ff <= ptr_r2_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff <= taps_in;
      ctrl_ff <= ctrl_in;
   end

   always_comb begin
      s2_slice[0] = taps_ff;
      s2_slice[1] = row_1;
      s2_slice[2] = row_2;
   end

   assign s2_valid = valid_ff;
   assign s2_ctrl  = ctrl_ff;

   `VSE_ASSERT(a_row_ptr_in_span, clock, reset, (WIDTH_REG_W'(ptr_r1_ff) < row_len) && (ROW_SPAN_W'(ptr_r2_ff) <= span_r2_last), "row buffer pointer outside its delay span")

endmodule

// ----- rtl/vse_window.sv -----
// 3x3x3 neighborhood window, surface decision and result register.
// Depends on vse_pkg.
module vse_window import vse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          s2_valid,
   output logic          s2_ready,
   input  vse_slice_type s2_slice,
   input  vse_ctrl_type  s2_ctrl,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_surface,
   output logic          rsp_last
);

   vse_slice_type [2:0] window_ff, window_in;
   logic                valid_ff, valid_in;
   vse_ctrl_type        ctrl_ff, ctrl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_surface_ff, rsp_surface_in;
   logic                rsp_last_ff, rsp_last_in;

   logic load;
   logic adv;
   logic out_load;
   logic center;
   logic surface;

   // Warm-up requests only shift the window and leave without a result.
   assign adv      = valid_ff & (~ctrl_ff.emit | ~rsp_valid_ff | rsp_ready);
   assign s2_ready = ~valid_ff | adv;
   assign load     = s2_valid & s2_ready;
   assign out_load = adv & ctrl_ff.emit;

   assign window_in = load ? {window_ff[1], window_ff[0], s2_slice} : window_ff;
   assign valid_in  = load | (valid_ff & ~adv);
   assign ctrl_in   = load ? s2_ctrl : ctrl_ff;

   // On the volume border an occupied voxel always has an outside neighbor;
   // inside, it is surface when any of the 27 taps is empty.
   assign center  = window_ff[1][1][1];
   assign surface = center & (ctrl_ff.border | ~(&window_ff));

   assign rsp_valid_in   = out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_surface_in = out_load ? surface : rsp_surface_ff;
   assign rsp_last_in    = out_load ? ctrl_ff.last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff      <= window_in;
      ctrl_ff        <= ctrl_in;
      rsp_surface_ff <= rsp_surface_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_surface = rsp_surface_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ----- tb/vse_tb_pkg.sv -----
// Request kinds shared by the surface extraction testbench top and its checker.
// Depends on nothing.
package vse_tb_pkg;

   typedef enum logic {
      REQ_VOXEL = 1'b0,
      REQ_DRAIN = 1'b1
   } req_kind_type;

endpackage

// ----- tb/voxel_surface_checker.sv -----
// Checker for voxel_surface_extract_3d_top: follows the size registers and the request
// stream, predicts each surface result and compares it with the result channel.
// Depends on vse_pkg and vse_tb_pkg.
module voxel_surface_checker import vse_pkg::*, vse_tb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_mode,
   input  logic                  req_occupied,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_surface,
   input  logic                  rsp_last,
   output int                    mismatch_total,
   output int                    results_owed,
   output int                    results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // two planes, two rows and three voxels of occupancy
   localparam int HIST_DEPTH = 2 * MAX_PLANE + 2 * MAX_WIDTH + 3;

   typedef struct packed {
      logic surface;
      logic last;
   } surface_flags_type;

   bit                      occ_hist [HIST_DEPTH];
   surface_flags_type       expected_flags_q [$];
   logic [WIDTH_REG_W-1:0]  size_w_reg;
   logic [HEIGHT_REG_W-1:0] size_h_reg;
   logic [DEPTH_REG_W-1:0]  size_d_reg;
   int                      voxel_idx;
   int                      col_at;
   int                      row_at;
   int                      plane_at;
   int                      mismatches;
   int                      checked;

   function automatic int clamp_size(int raw, int upper);
      if (raw < 1) return 1;
      if (raw > upper) return upper;
      return raw;
   endfunction

   task automatic restart_volume();
      voxel_idx = 0;
      col_at    = 0;
      row_at    = 0;
      plane_at  = 0;
   endtask

   task automatic predict_surface(input logic mode, input logic occ);
      int w, h, d, plane, total, lag, c, p, q;
      int dz, dy, dx, nz, ny, nx;
      logic surf;
      surface_flags_type flags;
      w     = clamp_size(int'(size_w_reg), MAX_WIDTH);
      h     = clamp_size(int'(size_h_reg), MAX_HEIGHT);
      d     = clamp_size(int'(size_d_reg), MAX_DEPTH);
      plane = w * h;
      total = plane * d;
      lag   = plane + w + 1;
      c     = voxel_idx;
      if (c < total) begin
         // drop a drain while the volume is still filling
         if (mode == REQ_DRAIN) return;
         occ_hist[c % HIST_DEPTH] = occ;
      end
      if (c < lag) begin
         voxel_idx = c + 1;
         return;
      end
      p    = c - lag;
      surf = 1'b0;
      if (occ_hist[p % HIST_DEPTH]) begin
         for (dz = -1; dz <= 1; dz++) begin
            for (dy = -1; dy <= 1; dy++) begin
               for (dx = -1; dx <= 1; dx++) begin
                  if (dz != 0 || dy != 0 || dx != 0) begin
                     nz = plane_at + dz;
                     ny = row_at + dy;
                     nx = col_at + dx;
                     if (nz < 0 || ny < 0 || nx < 0 || nz >= d || ny >= h || nx >= w) begin
                        surf = 1'b1;
                     end else begin
                        q = p + dz * plane + dy * w + dx;
                        if (!occ_hist[q % HIST_DEPTH]) surf = 1'b1;
                     end
                  end
               end
            end
         end
      end
      flags.surface = surf;
      flags.last    = (p == total - 1);
      expected_flags_q.push_back(flags);
      if (flags.last) begin
         restart_volume();
      end else begin
         voxel_idx = c + 1;
         col_at++;
         if (col_at >= w) begin
            col_at = 0;
            row_at++;
            if (row_at >= h) begin
               row_at = 0;
               plane_at++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      surface_flags_type flags;
      if (reset) begin
         size_w_reg = WIDTH_REG_W'(WIDTH_RESET);
         size_h_reg = HEIGHT_REG_W'(HEIGHT_RESET);
         size_d_reg = DEPTH_REG_W'(DEPTH_RESET);
         restart_volume();
         expected_flags_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_flags_q.size() == 0) begin
               $display("%0t: result surface=%0b last=%0b arrived with none expected",
                        $time, rsp_surface, rsp_last);
               mismatches++;
            end else begin
               flags = expected_flags_q.pop_front();
               if (rsp_surface !== flags.surface) begin
                  $display("%0t: surface expected %0b, got %0b",
                           $time, flags.surface, rsp_surface);
                  mismatches++;
               end
               if (rsp_last !== flags.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, flags.last, rsp_last);
                  mismatches++;
               end
               checked++;
            end
         end
         if (psel && penable && pwrite && pready) begin
            // any write to a size register restarts the volume; the spare index does not
            case (paddr[CSR_ADDR_W-1:2])
               REG_WIDTH: begin
                  size_w_reg = pwdata[WIDTH_REG_W-1:0];
                  restart_volume();
               end
               REG_HEIGHT: begin
                  size_h_reg = pwdata[HEIGHT_REG_W-1:0];
                  restart_volume();
               end
               REG_DEPTH: begin
                  size_d_reg = pwdata[DEPTH_REG_W-1:0];
                  restart_volume();
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_surface(req_mode, req_occupied);
      end
      mismatch_total  <= mismatches;
      results_owed    <= expected_flags_q.size();
      results_checked <= checked;
   end

endmodule

// ----- tb/voxel_surface_extract_3d_top_tb.sv -----
// Testbench top for voxel_surface_extract_3d_top: drives size writes, voxel and drain
// requests and result back-pressure; voxel_surface_checker does the checking.
// Depends on vse_pkg, vse_tb_pkg and voxel_surface_checker.
module voxel_surface_extract_3d_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vse_pkg::*;
   import vse_tb_pkg::*;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int DRAIN_CYCLES     = 12;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS     = 1750;
   localparam int DEEP_STOP        = 300;

   // paddr[3:2] value that selects no size register
   localparam logic [CSR_ADDR_W-3:0] REG_SPARE = 2'd3;

   typedef enum int {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_style_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  psel         = 1'b0;
   logic                  penable      = 1'b0;
   logic                  pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr        = '0;
   logic [CSR_DATA_W-1:0] pwdata       = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic                  req_mode     = 1'b0;
   logic                  req_occupied = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   logic                  rsp_surface;
   logic                  rsp_last;

   int mismatch_total;
   int results_owed;
   int results_checked;

   logic long_hold_armed = 1'b0;
   bit   steady_feed     = 1'b0;
   int   burst_left      = 0;
   int   vol_w           = 64;
   int   vol_h           = 64;
   int   vol_d           = 64;
   int   fed_count       = 0;
   int   volumes_done    = 0;
   int   settings_written = 0;
   int   cycle_count     = 0;

   voxel_surface_extract_3d_top dut (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_occupied (req_occupied),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_surface  (rsp_surface),
      .rsp_last     (rsp_last)
   );

   voxel_surface_checker surface_check (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_occupied    (req_occupied),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_surface     (rsp_surface),
      .rsp_last        (rsp_last),
      .mismatch_total  (mismatch_total),
      .results_owed    (results_owed),
      .results_checked (results_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, results_owed);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: stall in segments of changing style, plus one long hold on request
   initial begin : result_side
      rx_style_type style;
      int seg_left, period, phase;
      style    = RX_STEADY;
      seg_left = 0;
      period   = 2;
      phase    = 0;
      forever begin
         @(posedge clock);
         if (long_hold_armed) begin
            long_hold_armed <= 1'b0;
            rsp_ready       <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         if (seg_left == 0) begin
            style    = rx_style_type'($urandom_range(3));
            seg_left = $urandom_range(16, 160);
            period   = $urandom_range(2, 6);
            phase    = 0;
         end
         seg_left--;
         phase++;
         case (style)
            RX_STEADY:   rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= 1'($urandom_range(1));
            RX_SPARSE:   rsp_ready <= ($urandom_range(3) == 0);
            RX_PERIODIC: rsp_ready <= (phase % period == 0);
            default:     rsp_ready <= 1'b1;
         endcase
      end
   end

   task automatic send(input req_kind_type kind, input logic occ);
      int gap;
      if (burst_left == 0) begin
         gap = 0;
         if (!steady_feed && $urandom_range(3) != 0) gap = $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_mode     <= kind;
      req_occupied <= occ;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait until every result is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-3:0] index,
                            input logic [CSR_DATA_W-1:0] value, input bit release_bus);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (release_bus) begin
         psel    <= 1'b0;
         penable <= 1'b0;
         pwrite  <= 1'b0;
      end
   endtask

   // write all three sizes; bits above each field are junk the block must ignore
   task automatic set_volume(input int w_raw, input int h_raw, input int d_raw);
      settle();
      csr_write(REG_WIDTH, ($urandom << WIDTH_REG_W) | w_raw, 1'b0);
      csr_write(REG_HEIGHT, ($urandom << HEIGHT_REG_W) | h_raw, 1'b0);
      csr_write(REG_DEPTH, ($urandom << DEPTH_REG_W) | d_raw, 1'b1);
      vol_w = (w_raw < 1) ? 1 : ((w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw);
      vol_h = (h_raw < 1) ? 1 : ((h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw);
      vol_d = (d_raw < 1) ? 1 : ((d_raw > MAX_DEPTH) ? MAX_DEPTH : d_raw);
      settings_written++;
   endtask

   // one volume in raster order, then enough extra requests to flush it; stop early at stop_at
   task automatic run_volume(input int occ_pct, input int noise_pct, input int stop_at);
      int total, lag, i;
      total = vol_w * vol_h * vol_d;
      lag   = vol_w * vol_h + vol_w + 1;
      for (i = 0; i < total; i++) begin
         if (i == stop_at) return;
         if ($urandom_range(99) < noise_pct) send(REQ_DRAIN, 1'($urandom_range(1)));
         send(REQ_VOXEL, $urandom_range(99) < occ_pct);
         fed_count++;
      end
      // once the volume is full either kind of request only pushes results out
      for (i = 0; i < lag; i++) begin
         send(req_kind_type'($urandom_range(1)), 1'($urandom_range(1)));
         fed_count++;
      end
      volumes_done++;
   endtask

   function automatic int pick_dim();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 0;
      if (roll < 15) return $urandom_range(7, 10);
      return $urandom_range(1, 6);
   endfunction

   function automatic int pick_density();
      case ($urandom_range(3))
         0:       return 50;
         1:       return 85;
         2:       return 97;
         default: return 100;
      endcase
   endfunction

   initial begin : stimulus
      int w, h, d;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // drain into the reset-size volume: dropped
      send(REQ_DRAIN, 1'b1);
      // zero sizes act as one: a single-voxel volume
      set_volume(0, 0, 0);
      send(REQ_DRAIN, 1'b0);
      send(REQ_VOXEL, 1'b1);
      send(REQ_VOXEL, 1'b0);
      send(REQ_DRAIN, 1'b0);
      send(REQ_DRAIN, 1'b1);
      // next volume follows without any write
      send(REQ_VOXEL, 1'b0);
      repeat (3) send(REQ_DRAIN, 1'b0);

      set_volume(1, 1, 2);
      send(REQ_VOXEL, 1'b1);
      settle();
      // rewrite the same depth: restarts the volume
      csr_write(REG_DEPTH, 32'd2, 1'b1);
      send(REQ_VOXEL, 1'b1);
      send(REQ_VOXEL, 1'b0);
      settle();
      // spare index: ignored, the volume carries on
      csr_write(REG_SPARE, $urandom, 1'b1);
      repeat (3) send(REQ_DRAIN, 1'b1);

      // extreme sizes, clamped at the top of each field; cut the deep one short
      set_volume(127, 1, 2);
      run_volume(85, 5, -1);
      set_volume(1, 127, 1);
      run_volume(97, 5, -1);
      set_volume(0, 0, 8191);
      run_volume(90, 2, DEEP_STOP);

      // back-to-back volumes under a long result hold
      set_volume(4, 3, 5);
      steady_feed = 1'b1;
      run_volume(100, 0, -1);
      long_hold_armed <= 1'b1;
      run_volume(97, 0, -1);
      run_volume(50, 0, -1);
      steady_feed = 1'b0;

      while (fed_count < RANDOM_ITEMS) begin
         w = pick_dim();
         h = pick_dim();
         d = pick_dim();
         set_volume(w, h, d);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(7) == 0) begin
               // abandon the volume partway and restart it by rewriting the sizes
               run_volume(pick_density(), $urandom_range(10),
                          $urandom_range(vol_w * vol_h * vol_d - 1));
               set_volume(w, h, d);
            end else begin
               run_volume(pick_density(), $urandom_range(10), -1);
            end
         end
      end

      settle();
      $display("Covered %0d size settings and %0d full volumes; %0d results checked.",
               settings_written, volumes_done, results_checked);
      $display("Included clamped sizes, dropped drains, restarts and a long result hold.");
      if (mismatch_total == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vse_pkg.sv
rtl/vse_ram.sv
rtl/vse_ctrl.sv
rtl/vse_plane_buf.sv
rtl/vse_row_buf.sv
rtl/vse_window.sv
rtl/voxel_surface_extract_3d_top.sv
tb/vse_tb_pkg.sv
tb/voxel_surface_checker.sv
tb/voxel_surface_extract_3d_top_tb.sv
